### rtl/seven_segment_scan_sequencer_defines.svh
// Assertion macros for the seven-segment scan sequencer.
// No dependencies; included by the top level only.
`ifndef SEVEN_SEGMENT_SCAN_SEQUENCER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SEVSEG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("seven_segment_scan_sequencer: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SEVSEG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("seven_segment_scan_sequencer: next-cycle check failed");

`endif

### rtl/sevseg_pkg.sv
// Shared types, codes, constants and lookup tables of the seven-segment scan sequencer.
// No dependencies.
package sevseg_pkg;

    localparam int DIGIT_COUNT_DEF = 13;

    // Operation codes
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_SETALL = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_REPLY = 3'd5;

    // Configuration register indexes
    localparam logic CFG_ENABLE_MASK = 1'b0;
    localparam logic CFG_DOT_POS     = 1'b1;

    localparam logic [12:0] ENABLE_MASK_RST = 13'h1FFF;
    localparam logic [11:0] DOT_POS_RST     = 12'd650;

    localparam logic [7:0] DATA_REG  = 8'h48;
    localparam logic [7:0] READ_REG  = 8'hDD;
    localparam logic [7:0] DOT_AND   = 8'hFD;
    localparam logic [7:0] BLANK     = 8'hFF;
    localparam logic [7:0] SEG_CODES = 8'd12;
    localparam logic [3:0] FRAME_DIV = 4'd10;

    localparam logic [3:0] WORDS_INIT = 4'd8;
    localparam logic [3:0] WORDS_TICK = 4'd5;
    localparam logic [3:0] WORDS_ONE  = 4'd1;
    localparam logic [3:0] WORDS_NONE = 4'd0;

    typedef struct packed {
        logic       take;      // latch the accepted item and apply its state update
        logic       emit;      // load word word_idx into the output register
        logic       last;      // the emitted word ends the item
        logic [2:0] word_idx;
    } sevseg_cmd_t;

    typedef struct packed {
        logic       out_free;   // output register can take a word this cycle
        logic [3:0] word_total; // words owed by the latched item
    } sevseg_sts_t;

    function automatic logic [7:0] strobe_reg(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0:    r = 8'h3B;
            4'd1:    r = 8'h3A;
            4'd2:    r = 8'h39;
            4'd3:    r = 8'h38;
            4'd4:    r = 8'h37;
            4'd5:    r = 8'h36;
            4'd6:    r = 8'h30;
            4'd7:    r = 8'h31;
            4'd8:    r = 8'h32;
            4'd9:    r = 8'h33;
            4'd10:   r = 8'h35;
            4'd11:   r = 8'h34;
            4'd12:   r = 8'h26;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] p;
        case (code)
            4'd0:    p = 8'h06;
            4'd1:    p = 8'h5F;
            4'd2:    p = 8'h2A;
            4'd3:    p = 8'h0B;
            4'd4:    p = 8'h53;
            4'd5:    p = 8'h83;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'h1F;
            4'd8:    p = 8'h02;
            4'd9:    p = 8'h03;
            4'd10:   p = 8'h00;
            4'd11:   p = 8'h00;
            default: p = BLANK;
        endcase
        return p;
    endfunction

    // Expander set-up sequence: {register, data}
    function automatic logic [15:0] init_word(input logic [2:0] k);
        logic [15:0] w;
        case (k)
            3'd0:    w = {8'h04, 8'h01};
            3'd1:    w = {8'h0A, 8'h55};
            3'd2:    w = {8'h0B, 8'h55};
            3'd3:    w = {8'h0C, 8'h55};
            3'd4:    w = {8'h0D, 8'h55};
            3'd5:    w = {8'h0E, 8'h55};
            3'd6:    w = {8'h09, 8'h55};
            default: w = {8'h0F, 8'hFF};
        endcase
        return w;
    endfunction

endpackage

### rtl/seven_segment_scan_sequencer.sv
// Each item is taken while the controller is idle and is registered in the item latch;
// its words are then registered in the output register. An item owes N words (8 init,
// 5 tick, 1 read or reply, 0 otherwise), one word per cycle from the sequencer counter
// while the output register is free, else it waits on m_tready; no new item is taken until the current one is done.
// Reset (aresetn low, synchronous): digit store and pointers cleared, mask 8191,
// dot positions 650, no result pending.
`include "seven_segment_scan_sequencer_defines.svh"

module seven_segment_scan_sequencer #(
    parameter int DIGIT_COUNT = sevseg_pkg::DIGIT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // digit_index[3:0], digit_value[11:4], reply_byte[19:12]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // word_register[7:0], word_data[15:8], read_value[23:16],
                                   // knob_phase[25:24], button_pressed[26]
    output logic [1:0]  m_tuser,   // word_valid[0], frame_pulse[1]
    output logic        m_tlast
);
    import sevseg_pkg::*;

    sevseg_cmd_t cmd;
    sevseg_sts_t sts;

    sevseg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sevseg_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `SEVSEG_ASSERT_NXT(a_take_blocks_input, s_tvalid && s_tready, !s_tready)
    `SEVSEG_ASSERT_IMP(a_emit_needs_room, cmd.emit, sts.out_free && !s_tready)
    `SEVSEG_ASSERT_NXT(a_last_frees_input, cmd.emit && cmd.last, s_tready && m_tvalid && m_tlast)

endmodule

### rtl/sevseg_ctrl.sv
// Controller of the seven-segment scan sequencer: accepts one item, then
// steps the datapath through the item's words. Depends on sevseg_pkg.
module sevseg_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  sevseg_pkg::sevseg_sts_t sts,
    output sevseg_pkg::sevseg_cmd_t cmd
);
    import sevseg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       is_last;

    assign is_last = ({1'b0, cnt_reg} == (sts.word_total - 4'd1));

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.word_idx = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.word_total == WORDS_NONE) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = is_last;
                    cnt_next = cnt_reg + 3'd1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/sevseg_datapath.sv
// Datapath of the seven-segment scan sequencer: digit store, scan pointer,
// configuration registers, word builder and output register. Depends on sevseg_pkg.
module sevseg_datapath #(
    parameter int DIGIT_COUNT = sevseg_pkg::DIGIT_COUNT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sevseg_pkg::sevseg_cmd_t cmd,
    output sevseg_pkg::sevseg_sts_t sts,
    input  logic [23:0]             s_tdata,
    input  logic [2:0]              s_tuser,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [12:0]             cfg_wdata,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [31:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);
    import sevseg_pkg::*;

    localparam int         IDX_W      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(DIGIT_COUNT - 1);
    localparam logic [4:0] DC_W       = 5'(DIGIT_COUNT);

    // Configuration
    logic [12:0] mask_reg;
    logic [11:0] dot_reg;

    // Digit store and scan state
    logic [7:0]       store_reg [DIGIT_COUNT];
    logic [IDX_W-1:0] cur_reg, old_reg, new_reg;
    logic [3:0]       scan_reg;
    logic             fp_reg;

    // Latched item
    logic [2:0] op_reg;
    logic [3:0] idx_reg;
    logic [7:0] rep_reg;

    // Output register
    logic        mvalid_reg;
    logic [31:0] mdata_reg;
    logic [1:0]  muser_reg;
    logic        mlast_reg;

    logic [2:0]       in_op;
    logic [3:0]       in_idx;
    logic [7:0]       in_val, in_rep;
    logic             in_idx_ok, idx_ok;
    logic [IDX_W-1:0] old_d, new_d;
    logic [3:0]       scan_inc;

    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_byte;
    logic [15:0]      dot_ext, mask_ext;
    logic [7:0]       pattern;
    logic [15:0]      iw;

    logic [7:0] w_reg, w_data, w_rdval;
    logic       w_valid, w_btn, w_fp;
    logic [1:0] w_knob;

    assign in_op     = s_tuser;
    assign in_idx    = s_tdata[3:0];
    assign in_val    = s_tdata[11:4];
    assign in_rep    = s_tdata[19:12];
    assign in_idx_ok = ({1'b0, in_idx} < DC_W);
    assign idx_ok    = ({1'b0, idx_reg} < DC_W);

    // Pointer advance; an out-of-range pointer counts as the last digit
    always_comb begin
        old_d    = (cur_reg > LAST_DIGIT) ? LAST_DIGIT : cur_reg;
        new_d    = (old_d == LAST_DIGIT) ? '0 : IDX_W'(old_d + 1'b1);
        scan_inc = scan_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= ENABLE_MASK_RST;
            dot_reg  <= DOT_POS_RST;
            cur_reg  <= '0;
            scan_reg <= 4'd0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ENABLE_MASK) begin
                    mask_reg <= cfg_wdata;
                end else begin
                    dot_reg <= cfg_wdata[11:0];
                end
            end
            if (cmd.take) begin
                case (in_op)
                    OP_SET: begin
                        if (in_idx_ok) begin
                            store_reg[in_idx[IDX_W-1:0]] <= in_val;
                        end
                    end
                    OP_SETALL: begin
                        for (int i = 0; i < DIGIT_COUNT; i++) begin
                            store_reg[i] <= in_val;
                        end
                    end
                    OP_TICK: begin
                        cur_reg <= new_d;
                        if (new_d == '0) begin
                            scan_reg <= (scan_inc >= FRAME_DIV) ? 4'd0 : scan_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_INIT;
        end else if (cmd.take) begin
            op_reg <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            idx_reg <= in_idx;
            rep_reg <= in_rep;
            old_reg <= old_d;
            new_reg <= new_d;
            fp_reg  <= (new_d == '0) && (scan_inc >= FRAME_DIV);
        end
    end

    // Single read port: read digit addresses the item's index, tick the new digit
    assign rd_addr  = (op_reg == OP_READ) ? idx_reg[IDX_W-1:0] : new_reg;
    assign rd_byte  = store_reg[rd_addr];
    assign dot_ext  = {4'd0, dot_reg};
    assign mask_ext = {3'd0, mask_reg};
    assign iw       = init_word(cmd.word_idx);

    always_comb begin
        if (new_reg == LAST_DIGIT) begin
            pattern = rd_byte;
        end else if (rd_byte >= SEG_CODES) begin
            pattern = BLANK;
        end else begin
            pattern = seg_pattern(rd_byte[3:0]) &
                      (dot_ext[4'(new_reg)] ? DOT_AND : 8'hFF);
        end
    end

    always_comb begin
        w_reg   = 8'd0;
        w_data  = 8'd0;
        w_valid = 1'b0;
        w_rdval = 8'd0;
        w_knob  = 2'd0;
        w_btn   = 1'b0;
        w_fp    = 1'b0;
        case (op_reg)
            OP_INIT: begin
                w_valid = 1'b1;
                w_reg   = iw[15:8];
                w_data  = iw[7:0];
            end
            OP_READ: begin
                w_rdval = idx_ok ? rd_byte : BLANK;
            end
            OP_TICK: begin
                w_valid = 1'b1;
                w_fp    = fp_reg;
                case (cmd.word_idx)
                    3'd0: begin
                        w_reg = strobe_reg(4'(old_reg));
                    end
                    3'd1: begin
                        w_reg  = DATA_REG;
                        w_data = pattern;
                    end
                    3'd2: begin
                        w_reg  = strobe_reg(4'(new_reg));
                        w_data = {7'd0, mask_ext[4'(new_reg)]};
                    end
                    3'd3: begin
                        w_reg = READ_REG;
                    end
                    default: begin
                    end
                endcase
            end
            OP_REPLY: begin
                w_knob = ~rep_reg[2:1];
                w_btn  = ~rep_reg[0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.out_free = !mvalid_reg || m_tready;
        case (op_reg)
            OP_INIT:  sts.word_total = WORDS_INIT;
            OP_TICK:  sts.word_total = WORDS_TICK;
            OP_READ:  sts.word_total = WORDS_ONE;
            OP_REPLY: sts.word_total = WORDS_ONE;
            default:  sts.word_total = WORDS_NONE;
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mdata_reg <= {5'd0, w_btn, w_knob, w_rdval, w_data, w_reg};
            muser_reg <= {w_fp, w_valid};
            mlast_reg <= cmd.last;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule
